### rtl/etg_pkg.sv
package etg_pkg;

  // field and register widths
  localparam int DATA_W     = 16;
  localparam int DELTA_W    = 16;
  localparam int PASS_W     = 24;
  localparam int TICK_W     = 25;
  localparam int SUM_W      = TICK_W + 1;
  localparam int SPAN_W     = DATA_W + 1;
  localparam int SEL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_VALUE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EASING_SELECT = 3'd4;

  // repeat modes (any other code runs as once)
  localparam logic [SEL_W-1:0] MODE_LOOP     = 2'd1;
  localparam logic [SEL_W-1:0] MODE_PINGPONG = 2'd2;

  // easing curves (any other code runs as linear)
  localparam logic [SEL_W-1:0] EASE_COSINE = 2'd1;
  localparam logic [SEL_W-1:0] EASE_QUAD   = 2'd2;

  // pi/2 in Q30, used when the cosine table is built
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_MOD_W,
    S_FRAC,
    S_FRAC_W,
    S_EASE,
    S_QUAD_W,
    S_COS_RD0,
    S_COS_RD1,
    S_COS_RD2,
    S_COS_W,
    S_LERP,
    S_LERP_W,
    S_EMIT
  } etg_state_t;

  // divider command: start a run, fraction or remainder flavour
  typedef struct packed {
    logic start;
    logic frac;
  } div_cmd_t;

endpackage

### rtl/etg_serial_div.sv
module etg_serial_div #(
  parameter int RW = 26,
  parameter int QW = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  etg_pkg::div_cmd_t   cmd,
  input  logic [RW-1:0]       num,
  input  logic [RW-1:0]       den,
  output logic                done,
  output logic [RW-1:0]       rem,
  output logic [QW-1:0]       quot
);

  localparam int SW = $clog2(RW + 1);

  logic [RW-1:0] r_r, r_nxt;
  logic [RW-1:0] sh_r, sh_nxt;
  logic [RW-1:0] den_r, den_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          ge;
  logic [RW-1:0] red;

  // one compare and subtract per cycle
  assign ge  = (r_r >= den_r);
  assign red = ge ? (r_r - den_r) : r_r;

  // remainder flavour shifts dividend bits in, fraction flavour shifts zeros in
  always_comb begin
    r_nxt    = r_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      den_nxt  = den;
      q_nxt    = '0;
      if (cmd.frac) begin
        r_nxt   = num;
        sh_nxt  = '0;
        cnt_nxt = SW'(QW);
      end else begin
        r_nxt   = '0;
        sh_nxt  = num;
        cnt_nxt = SW'(RW);
      end
    end else if (busy_r) begin
      r_nxt   = {red[RW-2:0], sh_r[RW-1]};
      sh_nxt  = {sh_r[RW-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign rem  = red;
  assign quot = q_r;

endmodule

### rtl/etg_serial_mul.sv
module etg_serial_mul #(
  parameter int WA = 17,
  parameter int WB = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WA-1:0]      a,
  input  logic [WB-1:0]      b,
  output logic               done,
  output logic [WA+WB-1:0]   prod
);

  localparam int PW = WA + WB;
  localparam int SW = $clog2(WB + 1);

  logic [PW-1:0] p_r, p_nxt;
  logic [WA-1:0] a_r, a_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [WA:0]   sum;

  // add the multiplicand when the low multiplier bit is set
  assign sum = {1'b0, p_r[PW-1:WB]} + {1'b0, (p_r[0] ? a_r : {WA{1'b0}})};

  // shift-add, one multiplier bit per cycle
  always_comb begin
    p_nxt    = p_r;
    a_nxt    = a_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      p_nxt    = {{WA{1'b0}}, b};
      a_nxt    = a;
      cnt_nxt  = SW'(WB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[WB-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    a_r <= a_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

### rtl/etg_cos_rom.sv
module etg_cos_rom #(
  parameter int PHASE_BITS = 16,
  parameter int DEPTH      = 256
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH+1)-1:0]   rd_addr,
  output logic [PHASE_BITS:0]          rd_data
);

  import etg_pkg::*;

  localparam int          SHIFT = 60 - PHASE_BITS;
  localparam logic [63:0] ONE_Q = 64'd1 << PHASE_BITS;

  typedef logic [PHASE_BITS:0] tab_t [0:DEPTH];

  // sin^2 table in Q30 series arithmetic, rounded and kept non-decreasing
  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sq;
    logic [63:0] v;
    longint      sum;
    for (int k = 0; k <= DEPTH; k++) begin
      a    = (HALF_PI_Q30 * 64'(k)) / DEPTH;
      a2   = (a * a) >> 30;
      sum  = longint'(a);
      term = ((a * a2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * a2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * a2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * a2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * a2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * a2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * a2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      sq = 64'(sum) * 64'(sum);
      v  = (sq + (64'd1 << (SHIFT - 1))) >> SHIFT;
      if (v > ONE_Q) begin
        v = ONE_Q;
      end
      if (k > 0) begin
        if (v < 64'(tab[k-1])) begin
          v = 64'(tab[k-1]);
        end
      end
      tab[k] = v[PHASE_BITS:0];
    end
    return tab;
  endfunction

  localparam tab_t COS_TAB = build_tab();

  logic [PHASE_BITS:0] rd_data_r;

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= COS_TAB[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/eased_tween_generator.sv
// sequence: range check, wrap divide when the tick count is wrapped, fraction divide,
// a multiply for quadratic ease-out or neighbouring table reads and a multiply
// for half-cosine, lerp, emit; a finishing or zero-length update skips the divides
// flow: one update at a time; the next input transfer is taken in the cycle after the
// result is loaded into the output register, and an update after finishing is dropped
// with no result
// reset: sync active low, clears control registers, tick count, finished flag, no fill
module eased_tween_generator #(
  parameter int PHASE_BITS         = 16,
  parameter int COSINE_TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [etg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [etg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [etg_pkg::DELTA_W-1:0]         in_delta_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [etg_pkg::DATA_W-1:0]   out_tween_value,
  output logic                                out_done_event
);

  import etg_pkg::*;

  localparam int WB = PHASE_BITS + 1;
  localparam int WA = (WB > DATA_W) ? WB : DATA_W;
  localparam int PW = WA + WB;
  localparam int IW = $clog2(COSINE_TABLE_DEPTH + 1);
  localparam int XW = WB + IW;

  localparam logic [WB-1:0] PHASE_ONE = {1'b1, {PHASE_BITS{1'b0}}};
  localparam logic [IW-1:0] LAST_IDX  = IW'(COSINE_TABLE_DEPTH);

  // configuration and state
  logic [DATA_W-1:0] start_r, end_r;
  logic [PASS_W-1:0] pass_r;
  logic [SEL_W-1:0]  mode_r, ease_r;
  logic [TICK_W-1:0] tick_r;
  logic              finished_r;
  etg_state_t        state_r, state_nxt;
  logic              out_valid_r;

  // working registers
  logic [SUM_W-1:0]      t_r;
  logic [WB-1:0]         p_r, e_r, lo_r;
  logic [IW-1:0]         idx_r;
  logic [PHASE_BITS-1:0] f_r;
  logic [DATA_W-1:0]     val_r, out_value_r;
  logic                  done_item_r, out_done_r;

  // shared units
  div_cmd_t          div_cmd;
  logic [SUM_W-1:0]  div_num, div_den, div_rem;
  logic [WB-1:0]     div_quot;
  logic              div_done;
  logic              mul_start, mul_done;
  logic [WA-1:0]     mul_a;
  logic [WB-1:0]     mul_b;
  logic [PW-1:0]     mul_prod;
  logic [IW-1:0]     rom_addr;
  logic [WB-1:0]     rom_data;

  // mode decode and pass lengths
  logic              is_loop, is_ping, d_zero;
  logic [SUM_W-1:0]  d_ext, m_ext, wrap_len, frac_num;
  logic              out_load;

  assign is_loop  = (mode_r == MODE_LOOP);
  assign is_ping  = (mode_r == MODE_PINGPONG);
  assign d_zero   = (pass_r == '0);
  assign d_ext    = {2'b00, pass_r};
  assign m_ext    = {1'b0, pass_r, 1'b0};
  assign wrap_len = is_ping ? m_ext : d_ext;
  // pingpong folds the second half of the double pass back
  assign frac_num = (is_ping && (t_r > d_ext)) ? (m_ext - t_r) : t_r;
  assign out_load = !out_valid_r || out_ready;

  // cosine table position
  logic [XW-1:0]         x;
  logic [IW:0]           x_idx;
  logic [IW-1:0]         cos_hi_addr;
  logic [WB-1:0]         q;

  assign x           = XW'(p_r) * XW'(COSINE_TABLE_DEPTH);
  assign x_idx       = x[XW-1:PHASE_BITS];
  assign cos_hi_addr = (idx_r == LAST_IDX) ? idx_r : (idx_r + 1'b1);
  assign q           = PHASE_ONE - p_r;

  // lerp with floor of the scaled span
  logic [SPAN_W-1:0] span, span_abs;
  logic              span_neg;
  logic [DATA_W-1:0] span_mag, lerp_mag, lerp_off, lerp_val;
  logic [PW-1:0]     lerp_up;

  assign span     = {end_r[DATA_W-1], end_r} - {start_r[DATA_W-1], start_r};
  assign span_neg = span[SPAN_W-1];
  assign span_abs = span_neg ? (~span + 1'b1) : span;
  assign span_mag = span_abs[DATA_W-1:0];
  assign lerp_up  = mul_prod + PW'({PHASE_BITS{1'b1}});
  assign lerp_mag = span_neg ? lerp_up[PHASE_BITS+DATA_W-1:PHASE_BITS]
                             : mul_prod[PHASE_BITS+DATA_W-1:PHASE_BITS];
  assign lerp_off = span_neg ? (~lerp_mag + 1'b1) : lerp_mag;
  assign lerp_val = start_r + lerp_off;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !finished_r) state_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (is_loop || is_ping) begin
          if (d_zero) state_nxt = S_EASE;
          else if (t_r >= wrap_len) state_nxt = S_MOD_W;
          else state_nxt = S_FRAC;
        end else if (t_r >= d_ext) begin
          state_nxt = S_EASE;
        end else begin
          state_nxt = S_FRAC;
        end
      end
      S_MOD_W: begin
        if (div_done) state_nxt = S_FRAC;
      end
      S_FRAC: state_nxt = S_FRAC_W;
      S_FRAC_W: begin
        if (div_done) state_nxt = S_EASE;
      end
      S_EASE: begin
        case (ease_r)
          EASE_COSINE: state_nxt = S_COS_RD0;
          EASE_QUAD:   state_nxt = S_QUAD_W;
          default:     state_nxt = S_LERP;
        endcase
      end
      S_QUAD_W: begin
        if (mul_done) state_nxt = S_LERP;
      end
      S_COS_RD0: state_nxt = S_COS_RD1;
      S_COS_RD1: state_nxt = S_COS_RD2;
      S_COS_RD2: state_nxt = S_COS_W;
      S_COS_W: begin
        if (mul_done) state_nxt = S_LERP;
      end
      S_LERP: state_nxt = S_LERP_W;
      S_LERP_W: begin
        if (mul_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit commands and operand selection
  always_comb begin
    in_ready  = 1'b0;
    div_cmd   = '0;
    div_num   = '0;
    div_den   = d_ext;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rom_addr  = idx_r;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_RANGE: begin
        if ((is_loop || is_ping) && !d_zero && (t_r >= wrap_len)) begin
          div_cmd.start = 1'b1;
          div_num       = t_r;
          div_den       = wrap_len;
        end
      end
      S_FRAC: begin
        div_cmd.start = 1'b1;
        div_cmd.frac  = 1'b1;
        div_num       = frac_num;
      end
      S_EASE: begin
        if (ease_r == EASE_QUAD) begin
          mul_start = 1'b1;
          mul_a     = WA'(q);
          mul_b     = q;
        end
      end
      S_COS_RD1: rom_addr = cos_hi_addr;
      S_COS_RD2: begin
        mul_start = 1'b1;
        mul_a     = WA'(rom_data - lo_r);
        mul_b     = WB'(f_r);
      end
      S_LERP: begin
        mul_start = 1'b1;
        mul_a     = WA'(span_mag);
        mul_b     = e_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= '0;
      end_r       <= '0;
      pass_r      <= '0;
      mode_r      <= '0;
      ease_r      <= '0;
      tick_r      <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_START_VALUE:   start_r <= cfg_data[DATA_W-1:0];
          REG_END_VALUE:     end_r   <= cfg_data[DATA_W-1:0];
          REG_PASS_TICKS:    pass_r  <= cfg_data[PASS_W-1:0];
          REG_REPEAT_MODE:   mode_r  <= cfg_data[SEL_W-1:0];
          REG_EASING_SELECT: ease_r  <= cfg_data[SEL_W-1:0];
          default: ;
        endcase
      end
      // once pass completes
      if ((state_r == S_RANGE) && !is_loop && !is_ping && (t_r >= d_ext)) begin
        finished_r <= 1'b1;
      end
      // tick count is final once easing starts
      if (state_r == S_EASE) begin
        tick_r <= t_r[TICK_W-1:0];
      end
      // output register
      if ((state_r == S_EMIT) && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) t_r <= {1'b0, tick_r} + SUM_W'(in_delta_ticks);
      end
      S_RANGE: begin
        done_item_r <= 1'b0;
        if (is_loop || is_ping) begin
          if (d_zero) begin
            t_r <= '0;
            p_r <= is_ping ? PHASE_ONE : '0;
          end
        end else if (t_r >= d_ext) begin
          t_r         <= d_ext;
          p_r         <= PHASE_ONE;
          done_item_r <= 1'b1;
        end
      end
      S_MOD_W: begin
        if (div_done) t_r <= div_rem;
      end
      S_FRAC_W: begin
        if (div_done) p_r <= div_quot;
      end
      S_EASE: begin
        e_r <= p_r;
        if (x_idx >= (IW+1)'(COSINE_TABLE_DEPTH)) begin
          idx_r <= LAST_IDX;
          f_r   <= '0;
        end else begin
          idx_r <= x_idx[IW-1:0];
          f_r   <= x[PHASE_BITS-1:0];
        end
      end
      S_QUAD_W: begin
        if (mul_done) e_r <= PHASE_ONE - mul_prod[PHASE_BITS+WB-1:PHASE_BITS];
      end
      S_COS_RD1: lo_r <= rom_data;
      S_COS_W: begin
        if (mul_done) e_r <= lo_r + mul_prod[PHASE_BITS+WB-1:PHASE_BITS];
      end
      S_LERP_W: begin
        if (mul_done) val_r <= lerp_val;
      end
      S_EMIT: begin
        if (out_load) begin
          out_value_r <= val_r;
          out_done_r  <= done_item_r;
        end
      end
      default: ;
    endcase
  end

  // serial remainder and fraction unit
  etg_serial_div #(
    .RW (SUM_W),
    .QW (WB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .rem   (div_rem),
    .quot  (div_quot)
  );

  // serial shift-add multiplier
  etg_serial_mul #(
    .WA (WA),
    .WB (WB)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // half-cosine table
  etg_cos_rom #(
    .PHASE_BITS (PHASE_BITS),
    .DEPTH      (COSINE_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_tween_value = signed'(out_value_r);
  assign out_done_event  = out_done_r;

endmodule
